// File: rtl/kfne_pkg.sv
// Shared types, codes and character helpers for the keyboard FIFO block.
// Used by kfne_front, kfne_back and keyboard_fifo_with_number_entry.
package kfne_pkg;

	localparam logic [1:0] ACT_KEY    = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_STATUS = 2'd2;

	localparam logic [1:0] KIND_ECHO   = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [7:0] CH_ERR   = 8'h45;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] BYTE_MAX = 8'hff;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] key_code;
	} in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic       last;
	} out_t;

	typedef enum logic [2:0] {
		OP_RAW_PUSH = 3'd0,
		OP_LINE_KEY = 3'd1,
		OP_NEWLINE  = 3'd2,
		OP_READ     = 3'd3,
		OP_STATUS   = 3'd4
	} op_e;

	typedef struct packed {
		op_e        op;
		logic [7:0] key;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_link_t;

	function automatic logic [6:0] digit_value(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd99;
		if (c >= 8'h30 && c <= 8'h39) r = 7'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h7a) r = 7'(c - 8'h61) + 7'd10;
		else if (c >= 8'h41 && c <= 8'h5a) r = 7'(c - 8'h41) + 7'd10;
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
	endfunction

endpackage

// File: rtl/kfne_front.sv
// Front end: accepts input beats, classifies them into commands, and holds
// them in a two-entry queue for the back end. Depends on kfne_pkg.
module kfne_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  kfne_pkg::in_t       item,
	input  logic                mode,
	output kfne_pkg::cmd_link_t cmd,
	input  logic                cmd_pop
);

	kfne_pkg::cmd_t q_q [2];
	logic [1:0]     cnt_q;
	logic           rd_q;
	logic           wr_q;
	logic           keep;
	kfne_pkg::cmd_t c;

	always_comb begin
		keep = 1'b1;
		c.key = item.key_code;
		c.op = kfne_pkg::OP_STATUS;
		case (item.action)
			kfne_pkg::ACT_KEY: begin
				if (!mode) c.op = kfne_pkg::OP_RAW_PUSH;
				else if (item.key_code == kfne_pkg::CH_NL) c.op = kfne_pkg::OP_NEWLINE;
				else c.op = kfne_pkg::OP_LINE_KEY;
			end
			kfne_pkg::ACT_READ: c.op = kfne_pkg::OP_READ;
			kfne_pkg::ACT_STATUS: c.op = kfne_pkg::OP_STATUS;
			default: keep = 1'b0;
		endcase
	end

	logic do_push;
	logic do_pop;
	assign full = (cnt_q == 2'd2);
	assign do_push = push && !full && keep;
	assign do_pop = cmd_pop && (cnt_q != 2'd0);
	assign cmd.valid = (cnt_q != 2'd0);
	assign cmd.cmd = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			cnt_q <= 2'(cnt_q + {1'b0, do_push} - {1'b0, do_pop});
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) q_q[wr_q] <= c;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("command queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && !do_push) |=> (cnt_q == 2'd0))
		else $error("command appeared without a push");
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (cnt_q == 2'($past(cnt_q) - 2'd1)))
		else $error("pop did not drain the queue");

endmodule

// File: rtl/kfne_back.sv
// Back end: byte FIFO, line store, line parser sequencer and result queue.
// Depends on kfne_pkg.
module kfne_back #(
	parameter int FIFO_DEPTH = 16,
	parameter int LINE_LEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kfne_pkg::cmd_link_t cmd,
	output logic                cmd_pop,
	output logic                empty,
	input  logic                pop,
	output kfne_pkg::out_t      result
);

	localparam int FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int LA = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
	localparam int LW = $clog2(LINE_LEN + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_READ = 6'b000010,
		ST_PRD  = 6'b000100,
		ST_PCH  = 6'b001000,
		ST_PFIN = 6'b010000,
		ST_NL   = 6'b100000
	} st_t;

	typedef enum logic [5:0] {
		P_WS    = 6'b000001,
		P_START = 6'b000010,
		P_ZERO  = 6'b000100,
		P_ZX    = 6'b001000,
		P_DIG   = 6'b010000,
		P_STOP  = 6'b100000
	} pst_t;

	st_t            state_q;
	pst_t           pst_q;
	logic [7:0]     fifo_mem [FIFO_DEPTH];
	logic [7:0]     line_mem [LINE_LEN];
	logic [FW-1:0]  head_q;
	logic [FW-1:0]  tail_q;
	logic [7:0]     fifo_rd_q;
	logic [7:0]     line_rd_q;
	logic [LW-1:0]  len_q;
	logic [LW-1:0]  idx_q;
	logic [7:0]     c0_q, c1_q, c2_q, binv_q;
	logic           bin_q, neg_q;
	logic [4:0]     base_q;
	logic [8:0]     v_q;
	kfne_pkg::out_t oq_q [4];
	logic [1:0]     oq_rd_q, oq_wr_q;
	logic [2:0]     oq_cnt_q;

	logic [FW-1:0] head_nx, tail_nx;
	logic          fifo_ne, fifo_full;
	assign head_nx = (head_q == FW'(FIFO_DEPTH - 1)) ? '0 : FW'(head_q + 1'b1);
	assign tail_nx = (tail_q == FW'(FIFO_DEPTH - 1)) ? '0 : FW'(tail_q + 1'b1);
	assign fifo_ne = (head_q != tail_q);
	assign fifo_full = (head_nx == tail_q);

	// Per-character parse step.
	logic [7:0]  ch;
	logic [6:0]  dv;
	pst_t        pst_nx;
	logic [4:0]  base_nx;
	logic [8:0]  v_nx;
	logic        neg_nx, dig;
	logic [13:0] prod;
	assign ch = line_rd_q;
	assign dv = kfne_pkg::digit_value(ch);

	always_comb begin
		pst_nx = pst_q;
		base_nx = base_q;
		neg_nx = neg_q;
		dig = 1'b0;
		case (pst_q)
			P_WS: begin
				if (kfne_pkg::is_space(ch)) pst_nx = P_WS;
				else if (ch == kfne_pkg::CH_PLUS || ch == kfne_pkg::CH_MINUS) begin
					neg_nx = (ch == kfne_pkg::CH_MINUS);
					pst_nx = P_START;
				end else if (ch == kfne_pkg::CH_ZERO) pst_nx = P_ZERO;
				else begin
					base_nx = 5'd10;
					dig = 1'b1;
				end
			end
			P_START: begin
				if (ch == kfne_pkg::CH_ZERO) pst_nx = P_ZERO;
				else begin
					base_nx = 5'd10;
					dig = 1'b1;
				end
			end
			P_ZERO: begin
				if (ch == kfne_pkg::CH_LX || ch == kfne_pkg::CH_UX) pst_nx = P_ZX;
				else begin
					base_nx = 5'd8;
					dig = 1'b1;
				end
			end
			P_ZX: begin
				if (dv < 7'd16) begin
					base_nx = 5'd16;
					dig = 1'b1;
				end else pst_nx = P_STOP;
			end
			P_DIG: dig = 1'b1;
			P_STOP: pst_nx = P_STOP;
			default: pst_nx = P_STOP;
		endcase
		prod = 14'({5'd0, v_q} * {9'd0, base_nx}) + 14'(dv);
		v_nx = v_q;
		if (dig) begin
			if ({2'b00, dv} >= {4'b0000, base_nx}) pst_nx = P_STOP;
			else begin
				pst_nx = P_DIG;
				v_nx = (prod > 14'd255) ? 9'd256 : 9'(prod);
			end
		end
	end

	// Final line value.
	logic       pv_ok;
	logic [7:0] pv;
	always_comb begin
		if (idx_q == LW'(3) && c0_q == kfne_pkg::CH_QUOTE && c2_q == kfne_pkg::CH_QUOTE) begin
			pv_ok = 1'b1;
			pv = c1_q;
		end else if (idx_q == LW'(8) && bin_q) begin
			pv_ok = 1'b1;
			pv = binv_q;
		end else begin
			pv_ok = (v_q <= 9'd255) && !(neg_q && v_q != 9'd0);
			pv = v_q[7:0];
		end
	end

	logic           oq_room;
	logic           enq;
	kfne_pkg::out_t enq_d;
	logic           deq;
	logic           fifo_we;
	logic [7:0]     fifo_wd;
	assign oq_room = (oq_cnt_q <= 3'd2);
	assign deq = pop && !empty;
	assign empty = (oq_cnt_q == 3'd0);
	assign result = oq_q[oq_rd_q];

	always_comb begin
		cmd_pop = 1'b0;
		enq = 1'b0;
		enq_d = '{kind: kfne_pkg::KIND_ECHO, data: cmd.cmd.key, last: 1'b1};
		fifo_we = 1'b0;
		fifo_wd = cmd.cmd.key;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid && oq_room) begin
					cmd_pop = 1'b1;
					case (cmd.cmd.op)
						kfne_pkg::OP_RAW_PUSH: fifo_we = !fifo_full;
						kfne_pkg::OP_LINE_KEY: enq = 1'b1;
						kfne_pkg::OP_STATUS: begin
							enq = 1'b1;
							enq_d.kind = kfne_pkg::KIND_STATUS;
							enq_d.data = {7'd0, fifo_ne};
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				enq = 1'b1;
				enq_d.kind = kfne_pkg::KIND_READ;
				enq_d.data = fifo_ne ? fifo_rd_q : 8'd0;
			end
			ST_PFIN: begin
				if (pv_ok) begin
					fifo_we = !fifo_full;
					fifo_wd = pv;
					enq = 1'b1;
					enq_d.data = kfne_pkg::CH_NL;
				end else begin
					enq = 1'b1;
					enq_d.data = kfne_pkg::CH_ERR;
					enq_d.last = 1'b0;
				end
			end
			ST_NL: begin
				enq = 1'b1;
				enq_d.data = kfne_pkg::CH_NL;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pst_q <= P_WS;
			head_q <= '0;
			tail_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			oq_rd_q <= '0;
			oq_wr_q <= '0;
			oq_cnt_q <= '0;
			c0_q <= '0;
			c1_q <= '0;
			c2_q <= '0;
			binv_q <= '0;
			bin_q <= 1'b0;
			neg_q <= 1'b0;
			base_q <= 5'd10;
			v_q <= '0;
		end else begin
			if (fifo_we) head_q <= head_nx;
			if (enq) oq_wr_q <= oq_wr_q + 2'd1;
			if (deq) oq_rd_q <= oq_rd_q + 2'd1;
			oq_cnt_q <= 3'(oq_cnt_q + {2'b00, enq} - {2'b00, deq});
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.cmd.op)
							kfne_pkg::OP_LINE_KEY: begin
								if (len_q < LW'(LINE_LEN)) len_q <= LW'(len_q + 1'b1);
							end
							kfne_pkg::OP_READ: state_q <= ST_READ;
							kfne_pkg::OP_NEWLINE: begin
								state_q <= ST_PRD;
								pst_q <= P_WS;
								idx_q <= '0;
								bin_q <= 1'b1;
								neg_q <= 1'b0;
								base_q <= 5'd10;
								v_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					if (fifo_ne) tail_q <= tail_nx;
					state_q <= ST_IDLE;
				end
				ST_PRD: begin
					if (idx_q == len_q) state_q <= ST_PFIN;
					else state_q <= ST_PCH;
				end
				ST_PCH: begin
					if (ch == 8'd0) state_q <= ST_PFIN;
					else begin
						if (idx_q == LW'(0)) c0_q <= ch;
						if (idx_q == LW'(1)) c1_q <= ch;
						if (idx_q == LW'(2)) c2_q <= ch;
						if (idx_q < LW'(8)) begin
							if (ch != kfne_pkg::CH_ZERO && ch != kfne_pkg::CH_ONE) bin_q <= 1'b0;
							binv_q <= {binv_q[6:0], ch == kfne_pkg::CH_ONE};
						end
						pst_q <= pst_nx;
						base_q <= base_nx;
						neg_q <= neg_nx;
						v_q <= v_nx;
						idx_q <= LW'(idx_q + 1'b1);
						state_q <= ST_PRD;
					end
				end
				ST_PFIN: begin
					len_q <= '0;
					state_q <= pv_ok ? ST_IDLE : ST_NL;
				end
				ST_NL: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic line_we;
	assign line_we = cmd_pop && (cmd.cmd.op == kfne_pkg::OP_LINE_KEY) && (len_q < LW'(LINE_LEN));

	always_ff @(posedge clk) begin
		if (fifo_we) fifo_mem[head_q] <= fifo_wd;
		fifo_rd_q <= fifo_mem[tail_q];
		if (line_we) line_mem[len_q[LA-1:0]] <= cmd.cmd.key;
		line_rd_q <= line_mem[idx_q[LA-1:0]];
		if (enq) oq_q[oq_wr_q] <= enq_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n) oq_cnt_q <= 3'd4)
		else $error("result queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LW'(LINE_LEN))
		else $error("line length beyond store");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PCH) |-> ($past(state_q) == ST_PRD))
		else $error("character step without a read");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == ST_IDLE && oq_room))
		else $error("command taken while busy");

endmodule

// File: rtl/keyboard_fifo_with_number_entry.sv
// Top level of the keyboard port with byte FIFO and number entry.
// Depends on kfne_pkg, kfne_front and kfne_back.
//
//   channel  | handshake          | payload
//   input    | push / full        | item   (kfne_pkg::in_t)
//   result   | pop / empty        | result (kfne_pkg::out_t)
//   config   | mode_we            | mode_data (number mode)
//
// A key or status beat is handled in the back end's idle state; a read then
// passes ST_READ, which queues the registered FIFO byte (or 0 if empty).
// A newline in number mode walks the line store with a read state (ST_PRD)
// and a parse step (ST_PCH) per character, since line reads are registered.
// Reset is asynchronous and needs no clearing pass; the stores are unread
// until written. Up to two commands queue between front and back, and four
// results queue at the output, so either side may stall on its own.
module keyboard_fifo_with_number_entry #(
	parameter int FIFO_DEPTH = 16,
	parameter int LINE_LEN = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  kfne_pkg::in_t  item,
	output logic           empty,
	input  logic           pop,
	output kfne_pkg::out_t result,
	input  logic           mode_we,
	input  logic           mode_data
);

	logic                mode_q;
	kfne_pkg::cmd_link_t cmd;
	logic                cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (mode_we) begin
			mode_q <= mode_data;
		end
	end

	kfne_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.mode    (mode_q),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	kfne_back #(
		.FIFO_DEPTH (FIFO_DEPTH),
		.LINE_LEN   (LINE_LEN)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cmd_pop (cmd_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
